/* sv/sc2a_pkg.sv */
// sc2a_pkg: shared types, scan code constants and the AZERTY layout tables
// for the scan code to ASCII decoder; depends on nothing
`default_nettype none

package sc2a_pkg;

  localparam int unsigned CodeW = 16;
  localparam int unsigned CharW = 7;

  // scan codes with a fixed meaning
  localparam logic [CodeW-1:0] ScLshift = 16'h002A;
  localparam logic [CodeW-1:0] ScRshift = 16'h0036;
  localparam logic [CodeW-1:0] ScCaps   = 16'h003A;
  localparam logic [CodeW-1:0] ScAltgr  = 16'hE038;
  localparam logic [CodeW-1:0] ScSpace  = 16'h0039;
  localparam logic [CodeW-1:0] ScEnter  = 16'h001C;
  localparam logic [CodeW-1:0] ScRowLo  = 16'h0002;
  localparam logic [CodeW-1:0] ScRowHi  = 16'h000B;
  localparam logic [CodeW-1:0] ScLetEnd = 16'h0040;

  localparam logic [CharW-1:0] ChSpace  = 7'h20;
  localparam logic [CharW-1:0] ChEnter  = 7'h0A;
  localparam logic [CharW-1:0] ChCase   = 7'h20;

  // item held in the input register
  typedef struct packed {
    logic             valid;
    logic [CodeW-1:0] scan_code;
    logic             key_pressed;
  } key_stage_t;

  // modifier flags
  typedef struct packed {
    logic lshift;
    logic rshift;
    logic altgr;
    logic caps;
  } mods_t;

  // lowercase letter for codes below 0x40, zero when not a letter
  function automatic logic [CharW-1:0] letter_of(input logic [5:0] code);
    logic [CharW-1:0] c;
    case (code)
      6'h10: c = 7'h61;
      6'h11: c = 7'h7A;
      6'h12: c = 7'h65;
      6'h13: c = 7'h72;
      6'h14: c = 7'h74;
      6'h15: c = 7'h79;
      6'h16: c = 7'h75;
      6'h17: c = 7'h69;
      6'h18: c = 7'h6F;
      6'h19: c = 7'h70;
      6'h1E: c = 7'h71;
      6'h1F: c = 7'h73;
      6'h20: c = 7'h64;
      6'h21: c = 7'h66;
      6'h22: c = 7'h67;
      6'h23: c = 7'h68;
      6'h24: c = 7'h6A;
      6'h25: c = 7'h6B;
      6'h26: c = 7'h6C;
      6'h2C: c = 7'h77;
      6'h2D: c = 7'h78;
      6'h2E: c = 7'h63;
      6'h2F: c = 7'h76;
      6'h30: c = 7'h62;
      6'h31: c = 7'h6E;
      6'h32: c = 7'h6D;
      default: c = '0;
    endcase
    return c;
  endfunction

  // number row without modifiers, accented keys as plain letters
  function automatic logic [CharW-1:0] row_plain(input logic [3:0] idx);
    logic [CharW-1:0] c;
    case (idx)
      4'd0: c = 7'h26;
      4'd1: c = 7'h65;
      4'd2: c = 7'h22;
      4'd3: c = 7'h27;
      4'd4: c = 7'h28;
      4'd6: c = 7'h65;
      4'd7: c = 7'h21;
      4'd8: c = 7'h63;
      4'd9: c = 7'h61;
      default: c = '0;
    endcase
    return c;
  endfunction

  // number row with shift: the digits
  function automatic logic [CharW-1:0] row_shift(input logic [3:0] idx);
    logic [CharW-1:0] c;
    case (idx)
      4'd0: c = 7'h31;
      4'd1: c = 7'h32;
      4'd2: c = 7'h33;
      4'd3: c = 7'h34;
      4'd4: c = 7'h35;
      4'd5: c = 7'h36;
      4'd6: c = 7'h37;
      4'd7: c = 7'h38;
      4'd8: c = 7'h39;
      4'd9: c = 7'h30;
      default: c = '0;
    endcase
    return c;
  endfunction

  // number row with altgr
  function automatic logic [CharW-1:0] row_altgr(input logic [3:0] idx);
    logic [CharW-1:0] c;
    case (idx)
      4'd0: c = 7'h7C;
      4'd1: c = 7'h40;
      4'd2: c = 7'h23;
      4'd6: c = 7'h7B;
      4'd7: c = 7'h5B;
      4'd8: c = 7'h5D;
      4'd9: c = 7'h7D;
      default: c = '0;
    endcase
    return c;
  endfunction

  // full lookup of a non-modifier key press, zero means no character
  function automatic logic [CharW-1:0] translate(input logic [CodeW-1:0] code,
                                                 input mods_t m);
    logic             shift;
    logic             in_row;
    logic [3:0]       idx;
    logic [CharW-1:0] let_c;
    logic [CharW-1:0] c;
    shift  = m.lshift | m.rshift;
    in_row = (code >= ScRowLo) && (code <= ScRowHi);
    idx    = code[3:0] - ScRowLo[3:0];
    let_c  = (code < ScLetEnd) ? letter_of(code[5:0]) : '0;
    if (m.altgr) begin
      c = in_row ? row_altgr(idx) : '0;
    end else if (in_row) begin
      c = shift ? row_shift(idx) : row_plain(idx);
    end else if (let_c != '0) begin
      c = (shift ^ m.caps) ? (let_c - ChCase) : let_c;
    end else if (code == ScSpace) begin
      c = ChSpace;
    end else if (code == ScEnter) begin
      c = ChEnter;
    end else begin
      c = '0;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* sv/sc2a_if.sv */
// sc2a_key_if and sc2a_char_if: valid/ready channels of the decoder
// depends on sc2a_pkg for the payload widths
`default_nettype none

interface sc2a_key_if;
  import sc2a_pkg::*;
  logic             valid;
  logic             ready;
  logic [CodeW-1:0] scan_code;
  logic             key_pressed;

  modport source (output valid, output scan_code, output key_pressed, input ready);
  modport sink   (input valid, input scan_code, input key_pressed, output ready);
endinterface

interface sc2a_char_if;
  import sc2a_pkg::*;
  logic             valid;
  logic             ready;
  logic [CharW-1:0] ascii_char;

  modport source (output valid, output ascii_char, input ready);
  modport sink   (input valid, input ascii_char, output ready);
endinterface

`default_nettype wire

/* sv/sc2a_in_stage.sv */
// sc2a_in_stage: input register of the decoder, takes one key event a cycle while it is empty or its item moves on
// depends on sc2a_pkg and sc2a_key_if
`default_nettype none

module sc2a_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  sc2a_key_if.sink            in_ch,
  input  logic                advance,
  output sc2a_pkg::key_stage_t stg
);
  import sc2a_pkg::*;

  logic             valid_r, valid_nxt;
  logic [CodeW-1:0] code_r;
  logic             pressed_r;
  logic             take;

  // register frees up in the same cycle that its item moves on
  assign in_ch.ready = !valid_r || advance;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (take) begin
      code_r    <= in_ch.scan_code;
      pressed_r <= in_ch.key_pressed;
    end
  end

  assign stg.valid       = valid_r;
  assign stg.scan_code   = code_r;
  assign stg.key_pressed = pressed_r;

endmodule

`default_nettype wire

/* sv/sc2a_xlate.sv */
// sc2a_xlate: modifier flags, layout lookup and the result register
// depends on sc2a_pkg and sc2a_char_if
`default_nettype none

module sc2a_xlate (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sc2a_pkg::key_stage_t stg,
  output logic                 advance,
  sc2a_char_if.source          out_ch
);
  import sc2a_pkg::*;

  mods_t            mods_r, mods_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CharW-1:0] out_char_r;
  logic [CharW-1:0] ch;
  logic             is_mod;
  logic             has_result;
  logic             slot_free;

  // modifier keys never produce a character
  assign is_mod = (stg.scan_code == ScLshift) || (stg.scan_code == ScRshift) ||
                  (stg.scan_code == ScAltgr)  || (stg.scan_code == ScCaps);

  assign ch         = translate(stg.scan_code, mods_r);
  assign has_result = stg.key_pressed && !is_mod && (ch != '0);
  assign slot_free  = !out_valid_r || out_ch.ready;
  // an event with no character never waits on the result side
  assign advance    = stg.valid && (!has_result || slot_free);

  // flag updates for the event leaving the input register
  always_comb begin
    mods_nxt = mods_r;
    if (advance) begin
      case (stg.scan_code)
        ScLshift: mods_nxt.lshift = stg.key_pressed;
        ScRshift: mods_nxt.rshift = stg.key_pressed;
        ScAltgr:  mods_nxt.altgr  = stg.key_pressed;
        ScCaps:   mods_nxt.caps   = mods_r.caps ^ stg.key_pressed;
        default:  mods_nxt        = mods_r;
      endcase
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance && has_result) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mods_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mods_r      <= mods_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      out_char_r <= ch;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.ascii_char = out_char_r;

`ifndef SYNTHESIS
  // reset leaves every modifier flag clear
  a_reset_mods: assert property (@(posedge clk) !rst_n |=> (mods_r == '0))
    else $error("modifier flags not cleared by reset");

  // a held result never carries the null character
  a_no_null: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_char_r != '0))
    else $error("null character in result register");

  // a pending character does not overwrite a stalled result
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (stg.valid && has_result && out_valid_r && !out_ch.ready) |-> !advance)
    else $error("result overwritten while stalled");

  // left shift flag follows its last event
  a_lshift: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && stg.scan_code == ScLshift) |=> (mods_r.lshift == $past(stg.key_pressed)))
    else $error("left shift flag wrong after its event");

  // caps lock press flips the flag
  a_caps: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && stg.key_pressed && stg.scan_code == ScCaps) |=>
      (mods_r.caps != $past(mods_r.caps)))
    else $error("caps lock press did not toggle");
`endif

endmodule

`default_nettype wire

/* sv/scan_code_to_ascii_decoder.sv */
// scan_code_to_ascii_decoder: set-1 scan codes to ASCII on a Belgian AZERTY layout
// depends on sc2a_pkg, sc2a_if, sc2a_in_stage and sc2a_xlate
//
//   channel   dir  payload                           handshake
//   in_ch     in   scan_code[15:0], key_pressed      valid/ready
//   out_ch    out  ascii_char[6:0]                   valid/ready
//
// one key event per cycle unless out_ch stalls a character event; each event passes the
// input register, then flag update and table lookup into the result register
// rst_n is synchronous and clears the valid bits and all modifier flags
// events that give no character drain even while the result is stalled
// a character event waits in the input register while out_ch is stalled
`default_nettype none

module scan_code_to_ascii_decoder (
  input  logic         clk,
  input  logic         rst_n,
  sc2a_key_if.sink     in_ch,
  sc2a_char_if.source  out_ch
);
  import sc2a_pkg::*;

  key_stage_t stg;
  logic       advance;

  sc2a_in_stage u_in (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .advance (advance),
    .stg     (stg)
  );

  sc2a_xlate u_xlate (
    .clk     (clk),
    .rst_n   (rst_n),
    .stg     (stg),
    .advance (advance),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

/* bench/scan_code_to_ascii_decoder_tb.sv */
// scan_code_to_ascii_decoder_tb: drives key events into the scan code decoder, predicts
// the AZERTY characters in a scoreboard class and checks every character transfer
// depends on sc2a_pkg, sc2a_if and scan_code_to_ascii_decoder
`timescale 1ns / 1ps

module scan_code_to_ascii_decoder_tb;
  import sc2a_pkg::*;

  // first code of each letter row on the layout
  localparam logic [CodeW-1:0] TopRowCode = 16'h0010;
  localparam logic [CodeW-1:0] MidRowCode = 16'h001E;
  localparam logic [CodeW-1:0] BotRowCode = 16'h002C;
  localparam logic [CodeW-1:0] ExtPrefix  = 16'hE000;
  // marks a number row key with no character in that mode
  localparam byte unsigned     NoGlyph    = 8'h20;
  localparam byte unsigned     CaseOffset = 8'h20;
  localparam int               ItemTarget = 1450;

  // keeps its own modifier flags and the queue of characters still to come
  class key_char_scoreboard;
    bit                 lshift;
    bit                 rshift;
    bit                 altgr;
    bit                 caps;
    logic [CharW-1:0]   char_q[$];
    int unsigned        errors;
    byte unsigned       letters[64];
    string              row_plain;
    string              row_shift;
    string              row_altgr;

    function new();
      string top_row;
      string mid_row;
      string bot_row;
      top_row   = "azertyuiop";
      mid_row   = "qsdfghjkl";
      bot_row   = "wxcvbnm";
      row_plain = "&e\"'( e!ca";
      row_shift = "1234567890";
      row_altgr = "|@#   {[]}";
      foreach (letters[i]) letters[i] = 8'h00;
      for (int i = 0; i < top_row.len(); i++) letters[TopRowCode + i] = top_row[i];
      for (int i = 0; i < mid_row.len(); i++) letters[MidRowCode + i] = mid_row[i];
      for (int i = 0; i < bot_row.len(); i++) letters[BotRowCode + i] = bot_row[i];
    endfunction

    // character a key press gives under the current flags, zero for none
    function logic [CharW-1:0] char_for(logic [CodeW-1:0] code);
      byte unsigned     b;
      int               idx;
      logic [CharW-1:0] c;
      c = '0;
      if (code >= ScRowLo && code <= ScRowHi) begin
        idx = code - ScRowLo;
        if (altgr) b = row_altgr[idx];
        else if (lshift || rshift) b = row_shift[idx];
        else b = row_plain[idx];
        if (b != NoGlyph) c = b[CharW-1:0];
      end else if (!altgr) begin
        if (code < ScLetEnd && letters[code[5:0]] != 8'h00) begin
          b = letters[code[5:0]];
          if ((lshift || rshift) != caps) b = b - CaseOffset;
          c = b[CharW-1:0];
        end else if (code == ScSpace) begin
          c = ChSpace;
        end else if (code == ScEnter) begin
          c = ChEnter;
        end
      end
      return c;
    endfunction

    // accepted key event: flag update or the character it gives
    function void note_key(logic [CodeW-1:0] code, logic pressed);
      logic [CharW-1:0] c;
      if (code == ScLshift) begin
        lshift = pressed;
        return;
      end
      if (code == ScRshift) begin
        rshift = pressed;
        return;
      end
      if (code == ScAltgr) begin
        altgr = pressed;
        return;
      end
      if (!pressed) return;
      if (code == ScCaps) begin
        caps = !caps;
        return;
      end
      c = char_for(code);
      if (c == '0) return;
      char_q.push_back(c);
    endfunction

    // accepted character against the oldest one expected
    function void check_char(logic [CharW-1:0] got);
      logic [CharW-1:0] want;
      if (char_q.size() == 0) begin
        $display("%0t: unexpected character: expected none, actual 0x%02h", $time, got);
        errors++;
      end else begin
        want = char_q.pop_front();
        if (got !== want) begin
          $display("%0t: ascii_char mismatch: expected 0x%02h, actual 0x%02h",
                   $time, want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  sc2a_key_if  key_ch ();
  sc2a_char_if char_ch ();

  scan_code_to_ascii_decoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (key_ch),
    .out_ch (char_ch)
  );

  key_char_scoreboard sb = new();
  int                 burst_left;
  int                 item_count;
  logic [15:0]        rx_cycle;

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // receiver: stall pattern changes with bits 8:7 of its cycle counter
  initial begin
    char_ch.ready = 1'b0;
    rx_cycle = '0;
  end

  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 16'd1;
    case (rx_cycle[8:7])
      2'd0: begin
        char_ch.ready <= 1'b1;
      end
      2'd1: begin
        char_ch.ready <= 1'($urandom_range(0, 1));
      end
      2'd2: begin
        char_ch.ready <= (rx_cycle[1:0] == 2'd0);
      end
      default: begin
        char_ch.ready <= rx_cycle[4];
      end
    endcase
  end

  // character transfers go to the scoreboard
  always @(posedge clk) begin
    if (rst_n && char_ch.valid && char_ch.ready) sb.check_char(char_ch.ascii_char);
  end

  // one key event; the sender runs in bursts with random gaps between them
  task automatic send_key(input logic [CodeW-1:0] code, input logic pressed);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        key_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
    end
    key_ch.valid       <= 1'b1;
    key_ch.scan_code   <= code;
    key_ch.key_pressed <= pressed;
    do @(posedge clk); while (!key_ch.ready);
    sb.note_key(code, pressed);
    item_count++;
    burst_left--;
    @(negedge clk);
  endtask

  // a press of some single-byte key, sometimes followed by its release
  task automatic type_key(input logic [CodeW-1:0] code);
    send_key(code, 1'b1);
    if ($urandom_range(0, 2) == 0) send_key(code, 1'b0);
  endtask

  // a word typed while a modifier is held
  task automatic held_word(input logic [CodeW-1:0] mod_code, input bit row_only);
    int n;
    n = $urandom_range(1, 8);
    send_key(mod_code, 1'b1);
    repeat (n) begin
      if (row_only && $urandom_range(0, 3) != 0) type_key(16'($urandom_range(2, 11)));
      else type_key(16'($urandom_range(0, 63)));
    end
    send_key(mod_code, 1'b0);
  endtask

  // random stray event: any code, the extended page, or a release
  task automatic noise_key();
    case ($urandom_range(0, 2))
      0: send_key(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
      1: send_key(ExtPrefix | 16'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      default: send_key(16'($urandom_range(0, 63)), 1'b0);
    endcase
  endtask

  // limit on the whole run
  initial begin
    #2_000_000;
    $display("scan_code_to_ascii_decoder verification failed");
    $finish;
  end

  initial begin
    key_ch.valid       = 1'b0;
    key_ch.scan_code   = '0;
    key_ch.key_pressed = 1'b0;
    rst_n              = 1'b0;
    burst_left         = 0;
    item_count         = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, each key class, each modifier and the ignored cases
    send_key(16'h0000, 1'b1);
    send_key(16'hFFFF, 1'b0);
    send_key(16'hFFFF, 1'b1);
    send_key(TopRowCode, 1'b1);
    send_key(ScSpace, 1'b1);
    send_key(ScEnter, 1'b1);
    send_key(ScRowLo, 1'b1);
    send_key(ScRowLo + 16'd5, 1'b1);
    send_key(ScCaps, 1'b1);
    send_key(ScCaps, 1'b0);
    send_key(BotRowCode, 1'b1);
    send_key(ScLshift, 1'b1);
    send_key(ScRowHi, 1'b1);
    send_key(MidRowCode, 1'b1);
    send_key(ScLshift, 1'b0);
    send_key(ScRshift, 1'b1);
    send_key(ScRowLo + 16'd5, 1'b1);
    send_key(ScRshift, 1'b0);
    send_key(ScAltgr, 1'b1);
    send_key(ScRowLo, 1'b1);
    send_key(ScRowLo + 16'd4, 1'b1);
    send_key(TopRowCode, 1'b1);
    send_key(ScAltgr, 1'b0);
    send_key(TopRowCode, 1'b0);
    send_key(ExtPrefix | TopRowCode, 1'b1);

    // random: mostly typing and modifier words, some toggles and noise
    while (item_count < ItemTarget) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          repeat ($urandom_range(1, 8)) type_key(16'($urandom_range(0, 63)));
        end
        5: held_word(ScLshift, 1'b0);
        6: held_word(ScRshift, 1'b0);
        7: held_word(ScAltgr, 1'b1);
        8: begin
          send_key(ScCaps, 1'b1);
          send_key(ScCaps, 1'b0);
        end
        default: noise_key();
      endcase
    end
    key_ch.valid <= 1'b0;

    // drain
    while (sb.char_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("scan_code_to_ascii_decoder verification clean");
    end else begin
      $display("scan_code_to_ascii_decoder verification failed");
    end
    $finish;
  end

endmodule
